FILE: rtl/tcc_pkg.sv
`default_nettype none
package tcc_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = 16;

   localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] CELL_END = ADDR_W'(CELLS);

   localparam logic [2:0] CMD_PUT    = 3'd0;
   localparam logic [2:0] CMD_CLEAR  = 3'd1;
   localparam logic [2:0] CMD_MOVE   = 3'd2;
   localparam logic [2:0] CMD_SCROLL = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   localparam logic [7:0] REG_BACKGROUND = 8'd0;
   localparam logic [7:0] REG_TEXT       = 8'd1;

   typedef enum logic [3:0] {
      K_PUTC, K_NEWLINE, K_TAB, K_BKSP, K_CLEAR, K_MOVE, K_SCROLL, K_READ, K_NOP
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       char_code;
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] y;
      logic [ROW_W-1:0] lines;
   } op_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
      addr_of = ADDR_W'(row * COLUMNS) + ADDR_W'(col);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/tcc_ram.sv
`default_nettype none
module tcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/tcc_front.sv
`default_nettype none
module tcc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [2:0]      command,
   input  wire logic [7:0]      char_code,
   input  wire logic [6:0]      target_x,
   input  wire logic [4:0]      target_y,
   input  wire logic [4:0]      scroll_lines,
   output logic                 q_valid,
   output tcc_pkg::op_type      q_op,
   input  wire logic            q_pop
);
   tcc_pkg::op_type slot_ff [2];
   logic            wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]      count_ff, count_in;
   tcc_pkg::op_type op;
   logic            push;

   always_comb begin
      op.char_code = char_code;
      op.x = (target_x > tcc_pkg::LAST_COL) ? tcc_pkg::LAST_COL : target_x;
      op.y = (target_y > tcc_pkg::LAST_ROW) ? tcc_pkg::LAST_ROW : target_y;
      op.lines = (scroll_lines > tcc_pkg::ROW_W'(tcc_pkg::ROWS)) ?
                 tcc_pkg::ROW_W'(tcc_pkg::ROWS) : scroll_lines;
      unique case (command)
         tcc_pkg::CMD_PUT: begin
            priority if (char_code == tcc_pkg::CH_NEWLINE) op.kind = tcc_pkg::K_NEWLINE;
            else if (char_code == tcc_pkg::CH_TAB) op.kind = tcc_pkg::K_TAB;
            else if (char_code == tcc_pkg::CH_BACKSPACE) op.kind = tcc_pkg::K_BKSP;
            else op.kind = tcc_pkg::K_PUTC;
         end
         tcc_pkg::CMD_CLEAR:  op.kind = tcc_pkg::K_CLEAR;
         tcc_pkg::CMD_MOVE:   op.kind = tcc_pkg::K_MOVE;
         tcc_pkg::CMD_SCROLL: op.kind = (scroll_lines == '0) ? tcc_pkg::K_NOP
                                                               : tcc_pkg::K_SCROLL;
         // out-of-screen reads answer zero, like an unknown command
         tcc_pkg::CMD_READ: op.kind = (target_x <= tcc_pkg::LAST_COL &&
                                       target_y <= tcc_pkg::LAST_ROW) ?
                                      tcc_pkg::K_READ : tcc_pkg::K_NOP;
         default: op.kind = tcc_pkg::K_NOP;
      endcase
   end

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_op     = slot_ff[rp_ff];

   always_comb begin
      wp_in    = push ? ~wp_ff : wp_ff;
      rp_in    = q_pop ? ~rp_ff : rp_ff;
      count_in = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= op;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/tcc_back.sv
`default_nettype none
module tcc_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [7:0]                 attr,
   input  wire logic                       q_valid,
   input  wire tcc_pkg::op_type            q_op,
   output logic                            q_pop,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [tcc_pkg::ADDR_W-1:0]      out_position,
   output logic [tcc_pkg::COL_W-1:0]       out_column,
   output logic [tcc_pkg::ROW_W-1:0]       out_row,
   output logic [7:0]                      out_char,
   output logic [7:0]                      out_color
);
   typedef enum logic [4:0] {
      S_IDLE, S_PUT, S_FWD, S_AFTER_FWD, S_BACK, S_WALK_RD, S_WALK_CHK, S_BPUT,
      S_BEND, S_SC_SETUP, S_SC_RD, S_SC_WR, S_SC_BLANK, S_CLR, S_RD, S_RD_WAIT,
      S_DONE
   } state_type;

   state_type                     state_ff;
   tcc_pkg::kind_type             kind_ff;
   logic [7:0]                    ch_ff;
   logic [tcc_pkg::COL_W-1:0]     x_ff;
   logic [tcc_pkg::ROW_W-1:0]     y_ff, n_ff;
   logic [1:0]                    cnt_ff;
   logic [tcc_pkg::COL_W-1:0]     col_ff, lim_col_ff;
   logic [tcc_pkg::ROW_W-1:0]     line_ff, lim_line_ff;
   logic [tcc_pkg::ADDR_W-1:0]    dst_ff, off_ff, end_ff;
   logic [15:0]                   cell_ff;

   logic                          wr_en;
   logic [tcc_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
   logic [15:0]                   wr_data, rd_data;
   logic [tcc_pkg::ROW_W-1:0]     next_line;
   logic [tcc_pkg::COL_W-1:0]     next_col;
   logic                          out_free;

   tcc_ram #(.WIDTH(tcc_pkg::CELL_W), .DEPTH(tcc_pkg::CELLS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign out_free = !out_valid || out_ready;

   // one forward step of the cursor
   always_comb begin
      if (col_ff == tcc_pkg::LAST_COL) begin
         next_col  = '0;
         next_line = (line_ff == tcc_pkg::LAST_ROW) ? tcc_pkg::LAST_ROW
                                                    : line_ff + 1'b1;
      end else begin
         next_col  = col_ff + 1'b1;
         next_line = line_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tcc_pkg::addr_of(line_ff, col_ff);
      wr_data = {attr, tcc_pkg::CH_SPACE};
      rd_addr = dst_ff + off_ff;
      unique case (state_ff)
         S_PUT: begin
            wr_en   = 1'b1;
            wr_data = {attr, ch_ff};
         end
         S_BPUT: wr_en = 1'b1;
         S_SC_WR: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            wr_data = rd_data;
         end
         S_SC_BLANK, S_CLR: begin
            wr_en   = (dst_ff != tcc_pkg::CELL_END);
            wr_addr = dst_ff;
         end
         S_WALK_RD: rd_addr = tcc_pkg::addr_of(line_ff, col_ff - 1'b1);
         S_RD:      rd_addr = tcc_pkg::addr_of(y_ff, x_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         col_ff      <= '0;
         line_ff     <= '0;
         lim_col_ff  <= '0;
         lim_line_ff <= '0;
         out_valid   <= 1'b0;
      end else begin
         // S_DONE reloads the response register itself
         if (out_valid && out_ready && state_ff != S_DONE) begin
            out_valid <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  kind_ff <= q_op.kind;
                  ch_ff   <= q_op.char_code;
                  x_ff    <= q_op.x;
                  y_ff    <= q_op.y;
                  n_ff    <= q_op.lines;
                  cnt_ff  <= '0;
                  dst_ff  <= '0;
                  cell_ff <= '0;
                  unique case (q_op.kind)
                     tcc_pkg::K_PUTC: state_ff <= S_PUT;
                     tcc_pkg::K_TAB: begin
                        ch_ff    <= tcc_pkg::CH_SPACE;
                        state_ff <= S_PUT;
                     end
                     tcc_pkg::K_NEWLINE: begin
                        col_ff   <= '0;
                        line_ff  <= (line_ff == tcc_pkg::LAST_ROW) ? tcc_pkg::LAST_ROW
                                                                    : line_ff + 1'b1;
                        state_ff <= S_FWD;
                     end
                     tcc_pkg::K_BKSP:   state_ff <= S_BACK;
                     tcc_pkg::K_CLEAR:  state_ff <= S_CLR;
                     tcc_pkg::K_MOVE: begin
                        col_ff   <= q_op.x;
                        line_ff  <= q_op.y;
                        state_ff <= S_DONE;
                     end
                     tcc_pkg::K_SCROLL: state_ff <= S_SC_SETUP;
                     tcc_pkg::K_READ:   state_ff <= S_RD;
                     default:           state_ff <= S_DONE;
                  endcase
               end
            end
            S_PUT: state_ff <= S_FWD;
            S_FWD: begin
               col_ff  <= next_col;
               line_ff <= next_line;
               if (next_line == tcc_pkg::LAST_ROW) begin
                  n_ff     <= tcc_pkg::ROW_W'(1);
                  dst_ff   <= '0;
                  state_ff <= S_SC_SETUP;
               end else begin
                  state_ff <= S_AFTER_FWD;
               end
            end
            S_AFTER_FWD: begin
               priority if (kind_ff == tcc_pkg::K_TAB && cnt_ff != 2'd2) begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_PUT;
               end else if (kind_ff == tcc_pkg::K_NEWLINE) begin
                  state_ff <= S_BACK;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_BACK: begin
               priority if (col_ff <= lim_col_ff && line_ff <= lim_line_ff) begin
                  state_ff <= S_BEND;
               end else if (col_ff == '0) begin
                  if (line_ff != '0) begin
                     col_ff   <= tcc_pkg::LAST_COL;
                     line_ff  <= line_ff - 1'b1;
                     state_ff <= S_WALK_RD;
                  end else begin
                     state_ff <= S_BEND;
                  end
               end else begin
                  col_ff   <= col_ff - 1'b1;
                  state_ff <= S_BPUT;
               end
            end
            // walk left over trailing spaces of the row above
            S_WALK_RD:  state_ff <= (col_ff == '0) ? S_BPUT : S_WALK_CHK;
            S_WALK_CHK: begin
               if (rd_data[7:0] == tcc_pkg::CH_SPACE) begin
                  col_ff   <= col_ff - 1'b1;
                  state_ff <= S_WALK_RD;
               end else begin
                  state_ff <= S_BPUT;
               end
            end
            S_BPUT: state_ff <= S_BEND;
            S_BEND: begin
               if (kind_ff == tcc_pkg::K_NEWLINE) begin
                  lim_col_ff  <= col_ff;
                  lim_line_ff <= line_ff;
               end
               state_ff <= S_DONE;
            end
            S_SC_SETUP: begin
               off_ff   <= tcc_pkg::ADDR_W'(n_ff * tcc_pkg::COLUMNS);
               end_ff   <= tcc_pkg::CELL_END - tcc_pkg::ADDR_W'(n_ff * tcc_pkg::COLUMNS);
               state_ff <= S_SC_RD;
            end
            S_SC_RD: state_ff <= (dst_ff == end_ff) ? S_SC_BLANK : S_SC_WR;
            S_SC_WR: begin
               dst_ff   <= dst_ff + 1'b1;
               state_ff <= S_SC_RD;
            end
            S_SC_BLANK: begin
               if (dst_ff == tcc_pkg::CELL_END) begin
                  col_ff   <= '0;
                  line_ff  <= (line_ff >= n_ff) ? line_ff - n_ff : '0;
                  state_ff <= (kind_ff == tcc_pkg::K_SCROLL) ? S_DONE : S_AFTER_FWD;
               end else begin
                  dst_ff <= dst_ff + 1'b1;
               end
            end
            S_CLR: begin
               if (dst_ff == tcc_pkg::CELL_END) begin
                  col_ff      <= '0;
                  line_ff     <= '0;
                  lim_col_ff  <= '0;
                  lim_line_ff <= '0;
                  state_ff    <= S_DONE;
               end else begin
                  dst_ff <= dst_ff + 1'b1;
               end
            end
            S_RD:      state_ff <= S_RD_WAIT;
            S_RD_WAIT: begin
               cell_ff  <= rd_data;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  out_valid    <= 1'b1;
                  out_position <= tcc_pkg::addr_of(line_ff, col_ff);
                  out_column   <= col_ff;
                  out_row      <= line_ff;
                  out_char     <= cell_ff[7:0];
                  out_color    <= cell_ff[15:8];
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/text_console_cursor_engine_core.sv
// Text console engine: owns an 80 x 25 screen of char/attribute cells.
// req_ channel carries one command item (put char, clear, move cursor,
// scroll up, read cell); rsp_ channel returns one item per command with the
// cursor after it and, for a read, the cell contents. csr_ writes the
// background (index 0) and text (index 1) color nibbles; csr_ready is always
// high and writes are expected only while the engine is idle.
// A two-entry queue sits between the command decoder and the sequencer that
// drives the single-port-write screen RAM, so commands keep being taken while
// a response waits for rsp_tready.
// Backspace across a row walks left over the trailing spaces of the row
// above. Clear writes every cell; scroll copies each kept cell and blanks
// the rest. A put char on the bottom row scrolls.
// Commands run one at a time: a waiting command starts in the cycle after a
// response is loaded.
// Reset clears cursor, limit point and colors (text 7, background 0); the
// screen holds garbage until a clear command.
// A stalled rsp_tready holds the response; the engine stops after it.
`default_nettype none
module text_console_cursor_engine_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[2:0], char_code[10:3], target_x[17:11], target_y[22:18],
   // scroll_lines[27:23], zero [31:28]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // cursor_position[10:0], cursor_column[17:11], cursor_row[22:18],
   // cell_char[30:23], cell_color[38:31], zero [39]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [3:0]  csr_data
);
   logic [3:0]      bg_ff, fg_ff;
   logic            q_valid, q_pop;
   tcc_pkg::op_type q_op;
   logic [10:0]     position;
   logic [6:0]      column;
   logic [4:0]      row;
   logic [7:0]      cchar, ccolor;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff <= 4'd0;
         fg_ff <= 4'd7;
      end else if (csr_valid) begin
         if (csr_index == tcc_pkg::REG_BACKGROUND) bg_ff <= csr_data;
         if (csr_index == tcc_pkg::REG_TEXT)       fg_ff <= csr_data;
      end
   end

   tcc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .command      (req_tdata[2:0]),
      .char_code    (req_tdata[10:3]),
      .target_x     (req_tdata[17:11]),
      .target_y     (req_tdata[22:18]),
      .scroll_lines (req_tdata[27:23]),
      .q_valid      (q_valid),
      .q_op         (q_op),
      .q_pop        (q_pop)
   );

   tcc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .attr         ({bg_ff, fg_ff}),
      .q_valid      (q_valid),
      .q_op         (q_op),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_position (position),
      .out_column   (column),
      .out_row      (row),
      .out_char     (cchar),
      .out_color    (ccolor)
   );

   assign rsp_tdata = {1'b0, ccolor, cchar, row, column, position};
endmodule
`default_nettype wire
